// ----- design/asc_pkg.sv -----
// asc_pkg: shared types, constants and helpers for the ascii to integer parser
// no dependencies
package asc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int ACC_WIDTH   = 64;
    localparam int BASE_WIDTH  = 6;
    localparam int CONS_WIDTH  = 16;

    // parse phases
    localparam logic [1:0] PH_WS    = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_ZERO  = 2'd2;
    localparam logic [1:0] PH_DIGIT = 2'd3;

    // register indexes
    localparam logic REG_RADIX = 1'b0;
    localparam logic [BASE_WIDTH-1:0] RADIX_RESET = 6'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [BASE_WIDTH-1:0] BASE_16 = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_10 = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_8  = 6'd8;

    typedef struct packed {
        logic [1:0]             phase;
        logic                   negative;
        logic [ACC_WIDTH-1:0]   acc;
        logic [BASE_WIDTH-1:0]  base;
        logic [COUNT_WIDTH-1:0] cnt;
    } t_state;

    typedef struct packed {
        logic                  emit;
        logic [ACC_WIDTH-1:0]  value;
        logic [CONS_WIDTH-1:0] consumed;
        logic [7:0]            terminator;
    } t_result;

    typedef struct packed {
        logic                  ok;
        logic [BASE_WIDTH-1:0] val;
    } t_digit;

    function automatic t_digit digit_of(logic [7:0] c);
        t_digit d;
        logic [7:0] off;
        d   = '0;
        off = '0;
        if (c >= CH_0 && c <= CH_9) begin
            off = c - CH_0;
            d.ok = 1'b1;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            off = c - CH_LA + 8'd10;
            d.ok = 1'b1;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            off = c - CH_UA + 8'd10;
            d.ok = 1'b1;
        end
        d.val = off[BASE_WIDTH-1:0];
        return d;
    endfunction

    function automatic logic [CONS_WIDTH-1:0] to_consumed(logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+CONS_WIDTH-1:0] wide;
        logic [COUNT_WIDTH+CONS_WIDTH-1:0] lim;
        wide = {{CONS_WIDTH{1'b0}}, c};
        lim  = {{COUNT_WIDTH{1'b0}}, {CONS_WIDTH{1'b1}}};
        if (wide > lim) begin
            return {CONS_WIDTH{1'b1}};
        end
        return wide[CONS_WIDTH-1:0];
    endfunction

endpackage

// ----- design/ascii_to_integer_parser.sv -----
// ascii_to_integer_parser: streaming token parser, one character per beat
// result path: an accepted terminator is held in r_ch, then its result is registered in r_res
// throughput: one character per cycle unless a stalled result blocks the input; the multiply-add step is combinational
// reset: synchronous, radix returns to 10 and the parser to the whitespace phase
// depends on asc_pkg, asc_cfg, asc_step
module ascii_to_integer_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_ch,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_value,
    output logic [15:0]         o_consumed,
    output logic [7:0]          o_terminator,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import asc_pkg::*;

    logic [BASE_WIDTH-1:0] radix;
    logic                  r_in_valid;
    logic [7:0]            r_ch;
    t_state                r_state;
    t_state                n_state;
    t_result               step_res;
    logic                  r_out_valid;
    t_result               r_res;
    logic                  blocked;
    logic                  advance;
    logic                  in_acc;

    asc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_radix (radix)
    );

    asc_step u_step (
        .i_state  (r_state),
        .i_radix  (radix),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign blocked    = r_out_valid && i_out_stall;
    assign advance    = r_in_valid && !blocked;
    assign o_in_stall = r_in_valid && blocked;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && step_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch <= i_ch;
        end
        if (advance && step_res.emit) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_res.value;
    assign o_consumed   = r_res.consumed;
    assign o_terminator = r_res.terminator;

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.emit |=> r_state.phase == PH_WS && r_state.cnt == '0)
        else $error("parser did not return to start after a result");

    a_held_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && blocked |=> r_in_valid && $stable(r_ch))
        else $error("pending character lost while output blocked");

    a_digit_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_DIGIT |-> r_state.base != '0)
        else $error("digit phase with no base");

    a_ws_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_WS |-> r_state.acc == '0 && r_state.base == '0)
        else $error("whitespace phase with stale accumulator");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blocked |=> r_out_valid && $stable(r_res))
        else $error("result overwritten while stalled");

endmodule

// ----- design/asc_cfg.sv -----
// asc_cfg: apb register file holding the radix register
// depends on asc_pkg
module asc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [asc_pkg::BASE_WIDTH-1:0]  o_radix
);
    import asc_pkg::*;

    logic [BASE_WIDTH-1:0] r_radix;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (wr_en) begin
            r_radix <= pwdata[BASE_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RADIX) begin
            prdata = {{(32-BASE_WIDTH){1'b0}}, r_radix};
        end
    end

    assign o_radix = r_radix;

endmodule

// ----- design/asc_step.sv -----
// asc_step: next-state and result logic for one character
// depends on asc_pkg
module asc_step (
    input  asc_pkg::t_state                 i_state,
    input  logic [asc_pkg::BASE_WIDTH-1:0]  i_radix,
    input  logic [7:0]                      i_ch,
    output asc_pkg::t_state                 o_state,
    output asc_pkg::t_result                o_result
);
    import asc_pkg::*;

    t_state  s;
    t_result r;
    t_digit  d;
    logic    done;
    logic    take;

    always_comb begin
        s    = i_state;
        r    = '0;
        done = 1'b0;
        take = 1'b0;
        d    = digit_of(i_ch);

        if (s.phase == PH_WS) begin
            if (i_ch == CH_SPACE || i_ch == CH_TAB) begin
                take = 1'b1;
                done = 1'b1;
            end else begin
                s.phase = PH_SIGN;
                if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
                    s.negative = (i_ch == CH_MINUS);
                    take = 1'b1;
                    done = 1'b1;
                end
            end
        end

        if (!done) begin
            if (s.phase == PH_SIGN) begin
                if (i_ch == CH_0 && (i_radix == '0 || i_radix == BASE_16)) begin
                    s.base  = i_radix;
                    s.phase = PH_ZERO;
                    take = 1'b1;
                    done = 1'b1;
                end else begin
                    s.base  = (i_radix == '0) ? BASE_10 : i_radix;
                    s.phase = PH_DIGIT;
                end
            end else if (s.phase == PH_ZERO) begin
                s.phase = PH_DIGIT;
                if (i_ch == CH_X) begin
                    s.base = BASE_16;
                    take = 1'b1;
                    done = 1'b1;
                end else begin
                    s.base = (s.base == '0) ? BASE_8 : BASE_16;
                    s.acc  = '0;
                end
            end
        end

        if (!done) begin
            if (d.ok && d.val < s.base) begin
                s.acc = s.acc * {{(ACC_WIDTH-BASE_WIDTH){1'b0}}, s.base}
                      + {{(ACC_WIDTH-BASE_WIDTH){1'b0}}, d.val};
                take = 1'b1;
            end else begin
                r.emit       = 1'b1;
                r.value      = s.negative ? ('0 - s.acc) : s.acc;
                r.consumed   = to_consumed(s.cnt);
                r.terminator = i_ch;
                s            = '0;
                s.phase      = PH_WS;
            end
        end

        // saturating character count
        if (take && s.cnt != {COUNT_WIDTH{1'b1}}) begin
            s.cnt = s.cnt + 1'b1;
        end

        o_state  = s;
        o_result = r;
    end

endmodule

// ----- bench/ascii_to_integer_parser_chk.sv -----
`timescale 1ns / 1ps
// ascii_to_integer_parser_chk: tracks radix writes and character beats, predicts each
// token result and compares it with the result beats of the parser
// depends on asc_pkg
module ascii_to_integer_parser_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_value,
    input  logic [15:0] i_consumed,
    input  logic [7:0]  i_terminator,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    import asc_pkg::*;

    localparam logic [2:0] ADDR_RADIX = 3'(4 * REG_RADIX);
    localparam logic [BASE_WIDTH-1:0] RADIX_AUTO = '0;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] consumed;
        logic [7:0]  terminator;
    } t_token;

    t_token expected_tokens[$];

    logic [BASE_WIDTH-1:0]  radix_q;
    logic [BASE_WIDTH-1:0]  base_q;
    logic [1:0]             phase_q;
    logic                   neg_q;
    logic [63:0]            acc_q;
    logic [COUNT_WIDTH-1:0] cnt_q;

    function automatic logic [7:0] digit_value(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            return c - CH_0;
        end
        if (c >= CH_LA && c <= CH_LZ) begin
            return c - CH_LA + 8'd10;
        end
        if (c >= CH_UA && c <= CH_UZ) begin
            return c - CH_UA + 8'd10;
        end
        return 8'hFF;
    endfunction

    task automatic clear_token();
        phase_q = PH_WS;
        neg_q   = 1'b0;
        acc_q   = '0;
        base_q  = '0;
        cnt_q   = '0;
    endtask

    task automatic bump_count();
        if (cnt_q != '1) begin
            cnt_q = cnt_q + 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [7:0] d;
        t_token     t;
        if (phase_q == PH_WS) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                bump_count();
                return;
            end
            phase_q = PH_SIGN;
            if (c == CH_PLUS || c == CH_MINUS) begin
                neg_q = (c == CH_MINUS);
                bump_count();
                return;
            end
        end
        if (phase_q == PH_SIGN) begin
            if (c == CH_0 && (radix_q == RADIX_AUTO || radix_q == BASE_16)) begin
                base_q  = radix_q;
                phase_q = PH_ZERO;
                bump_count();
                return;
            end
            base_q  = (radix_q == RADIX_AUTO) ? BASE_10 : radix_q;
            phase_q = PH_DIGIT;
        end else if (phase_q == PH_ZERO) begin
            phase_q = PH_DIGIT;
            if (c == CH_X) begin
                base_q = BASE_16;
                bump_count();
                return;
            end
            // the leading zero counts as a digit of value zero
            base_q = (base_q == RADIX_AUTO) ? BASE_8 : BASE_16;
            acc_q  = '0;
        end
        d = digit_value(c);
        if (d < {2'b00, base_q}) begin
            acc_q = acc_q * {58'd0, base_q} + {56'd0, d};
            bump_count();
            return;
        end
        t.value      = neg_q ? (64'd0 - acc_q) : acc_q;
        t.consumed   = (32'(cnt_q) > 32'hFFFF) ? 16'hFFFF : 16'(cnt_q);
        t.terminator = c;
        expected_tokens.push_back(t);
        clear_token();
    endtask

    task automatic compare_token();
        t_token e;
        if (expected_tokens.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_SHOWN) begin
                $display("unexpected result beat: value %h consumed %0d terminator %h",
                         i_value, i_consumed, i_terminator);
            end
            return;
        end
        e = expected_tokens.pop_front();
        if (e.value !== i_value || e.consumed !== i_consumed
                || e.terminator !== i_terminator) begin
            o_fail_count++;
            if (o_fail_count <= MAX_SHOWN) begin
                $display("result mismatch: expected value %h consumed %0d terminator %h",
                         e.value, e.consumed, e.terminator);
                $display("                 actual   value %h consumed %0d terminator %h",
                         i_value, i_consumed, i_terminator);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_q = RADIX_RESET;
            clear_token();
            expected_tokens.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_RADIX) begin
                radix_q = i_pwdata[BASE_WIDTH-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_ch);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_token();
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

// ----- bench/ascii_to_integer_parser_tb.sv -----
`timescale 1ns / 1ps
// ascii_to_integer_parser_tb: drives character beats, radix writes and result stalls
// into the parser; depends on asc_pkg, ascii_to_integer_parser, ascii_to_integer_parser_chk
module ascii_to_integer_parser_tb;
    import asc_pkg::*;

    localparam logic [2:0] ADDR_RADIX = 3'(4 * REG_RADIX);
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam int PHASES = 10;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_ch         = '0;
    logic        i_out_stall  = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic signed [63:0] o_value;
    logic [15:0] o_consumed;
    logic [7:0]  o_terminator;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int beats_sent = 0;
    logic [BASE_WIDTH-1:0] cur_radix = RADIX_RESET;

    int radix_plan [PHASES] = '{0, 36, 10, 16, 2, 1, 63, 8, 0, 37};
    int idle_plan  [4]      = '{0, 50, 0, 34};
    int stall_plan [4]      = '{0, 0, 50, 34};

    ascii_to_integer_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_consumed   (o_consumed),
        .o_terminator (o_terminator),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ascii_to_integer_parser_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_value      (o_value),
        .i_consumed   (o_consumed),
        .i_terminator (o_terminator),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] c);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [BASE_WIDTH-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RADIX;
        pwdata  <= {26'($urandom()), r};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_radix = r;
    endtask

    function automatic logic [7:0] digit_char(int v);
        if (v < 10) begin
            return CH_0 + 8'(v);
        end
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    task automatic send_token();
        int kind;
        int b;
        int n;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 2)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        case ($urandom_range(2))
            1: send_byte(CH_PLUS);
            2: send_byte(CH_MINUS);
            default: ;
        endcase
        b = cur_radix;
        if (b == 0 || b == 16) begin
            case ($urandom_range(3))
                0: begin
                    send_byte(CH_0);
                    send_byte(CH_X);
                    b = 16;
                end
                1: begin
                    send_byte(CH_0);
                    if (b == 0) b = 8;
                end
                default: begin
                    if (b == 0) b = 10;
                end
            endcase
        end
        if (b > 36) b = 36;
        n = $urandom_range(0, (kind < 25) ? 24 : 8);
        repeat (n) begin
            if (b <= 1 || $urandom_range(19) == 0) begin
                c = digit_char($urandom_range(35));
            end else begin
                c = digit_char($urandom_range(b - 1));
            end
            send_byte(c);
        end
        case ($urandom_range(4))
            0: send_byte(8'($urandom_range(255)));
            1: send_byte(CH_SPACE);
            2: send_byte(CH_SEMI);
            3: send_byte(8'h00);
            default: send_byte(8'hFF);
        endcase
    endtask

    initial begin
        int p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed tokens at the reset radix
        send_text("\t-12;");
        send_text("-q");
        send_byte(8'h00);
        send_text("9");
        send_byte(8'hFF);

        // prefix detection, bare hex prefix, octal
        wait_idle();
        write_radix(6'd0);
        send_text("0xF ");
        send_text("0x!");
        send_text("07 ");

        // radix one ends on any digit but zero, radix above 36 takes every digit
        wait_idle();
        write_radix(6'd1);
        send_text("5");
        wait_idle();
        write_radix(6'd63);
        send_text("z");
        send_byte(8'hFF);

        // radix changed before the prefix is resolved
        send_text(" -");
        wait_idle();
        write_radix(BASE_16);
        send_text("0xf;");

        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            write_radix(6'(radix_plan[p]));
            idle_pct   = idle_plan[p % 4];
            stall_pct  = stall_plan[p % 4];
            beats_sent = 0;
            while (beats_sent < 135) begin
                send_token();
            end
        end

        // long hold-off on the result side while short tokens keep coming
        wait_idle();
        write_radix(BASE_10);
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (40) begin
            send_byte(CH_0 + 8'd5);
            send_byte(CH_SPACE);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
